### hw/rtl/mbe_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time block.
// Used by mbe_cfg, mbe_ctrl, mbe_dp, mandelbrot_escape_time and the testbench; no dependencies.
`default_nettype none

package mbe_pkg;

    // Q4.28 fixed point for c and z
    localparam int unsigned FRAC_BITS  = 28;
    localparam int unsigned COORD_W    = 32;
    localparam int unsigned PROD_W     = 2 * COORD_W;
    localparam int unsigned PIX_W      = 10;
    localparam int unsigned ITER_W     = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // |z|^2 escape bound, 4.0 in Q8.56
    localparam logic [PROD_W-1:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_RE_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RE_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IM_ORIGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IM_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd4;

    // Reset values: window [-2, 2) at 1/256 per pixel, limit 100
    localparam logic signed [COORD_W-1:0] RST_RE_ORIGIN = -32'sd536870912;
    localparam logic signed [COORD_W-1:0] RST_RE_STEP   = 32'sd1048576;
    localparam logic signed [COORD_W-1:0] RST_IM_ORIGIN = -32'sd536870912;
    localparam logic signed [COORD_W-1:0] RST_IM_STEP   = 32'sd1048576;
    localparam logic [ITER_W-1:0]         RST_MAX_ITER  = 16'd100;

    typedef struct packed {
        logic signed [COORD_W-1:0] re_origin;
        logic signed [COORD_W-1:0] re_step;
        logic signed [COORD_W-1:0] im_origin;
        logic signed [COORD_W-1:0] im_step;
        logic [ITER_W-1:0]         max_iter;
    } cfg_t;

    // Operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MUL_MAP_RE = 3'd0,
        MUL_MAP_IM = 3'd1,
        MUL_ZR2    = 3'd2,
        MUL_ZI2    = 3'd3,
        MUL_RI     = 3'd4
    } mul_sel_t;

    typedef struct packed {
        logic     load;    // capture pixel, clear z and count
        mul_sel_t mul_sel;
        logic     cr_en;   // map real part from product
        logic     ci_en;   // map imaginary part from product
        logic     rr_en;   // hold zr^2
        logic     ii_en;   // hold zi^2
        logic     upd_en;  // advance z and count
    } dp_cmd_t;

    typedef struct packed {
        logic stop;        // escaped or limit reached
    } dp_status_t;

    // Clamp a 64-bit signed value to the 32-bit Q4.28 range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < lo)
        begin
            return -32'sh8000_0000;
        end
        return $signed(v[COORD_W-1:0]);
    endfunction

    function automatic logic signed [PROD_W-1:0] sext64(input logic signed [COORD_W-1:0] v);
        return $signed({{COORD_W{v[COORD_W-1]}}, v});
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mbe_cfg.sv
// Configuration register file: window origin, step and iteration limit.
// Depends on mbe_pkg.
`default_nettype none

module mbe_cfg
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mbe_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mbe_pkg::cfg_t                          cfg
);

    mbe_pkg::cfg_t cfg_reg;
    mbe_pkg::cfg_t cfg_next;

    // User writes only while the block is idle; unenforced, all taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mbe_pkg::REG_RE_ORIGIN: cfg_next.re_origin = $signed(cfg_data);
                mbe_pkg::REG_RE_STEP:   cfg_next.re_step   = $signed(cfg_data);
                mbe_pkg::REG_IM_ORIGIN: cfg_next.im_origin = $signed(cfg_data);
                mbe_pkg::REG_IM_STEP:   cfg_next.im_step   = $signed(cfg_data);
                mbe_pkg::REG_MAX_ITER:  cfg_next.max_iter  = cfg_data[mbe_pkg::ITER_W-1:0];
                default:                cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.re_origin <= mbe_pkg::RST_RE_ORIGIN;
            cfg_reg.re_step   <= mbe_pkg::RST_RE_STEP;
            cfg_reg.im_origin <= mbe_pkg::RST_IM_ORIGIN;
            cfg_reg.im_step   <= mbe_pkg::RST_IM_STEP;
            cfg_reg.max_iter  <= mbe_pkg::RST_MAX_ITER;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mbe_ctrl.sv
// Sequencer for the escape-time datapath: mapping, then square/test/update loop.
// Depends on mbe_pkg.
`default_nettype none

module mbe_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    output logic                     done,
    output mbe_pkg::dp_cmd_t         cmd,
    input  wire mbe_pkg::dp_status_t status
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MAP_RE = 9'b000000010,
        S_MAP_IM = 9'b000000100,
        S_MAP_FN = 9'b000001000,
        S_SQ_RE  = 9'b000010000,
        S_SQ_IM  = 9'b000100000,
        S_TEST   = 9'b001000000,
        S_UPDATE = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = mbe_pkg::MUL_ZR2;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MAP_RE;
                end
            end
            S_MAP_RE:
            begin
                cmd.mul_sel = mbe_pkg::MUL_MAP_RE;
                state_next  = S_MAP_IM;
            end
            S_MAP_IM:
            begin
                cmd.mul_sel = mbe_pkg::MUL_MAP_IM;
                cmd.cr_en   = 1'b1;
                state_next  = S_MAP_FN;
            end
            S_MAP_FN:
            begin
                // z is zero here, so this state doubles as the first zr^2 step
                cmd.mul_sel = mbe_pkg::MUL_ZR2;
                cmd.ci_en   = 1'b1;
                state_next  = S_SQ_IM;
            end
            S_SQ_RE:
            begin
                cmd.mul_sel = mbe_pkg::MUL_ZR2;
                state_next  = S_SQ_IM;
            end
            S_SQ_IM:
            begin
                cmd.mul_sel = mbe_pkg::MUL_ZI2;
                cmd.rr_en   = 1'b1;
                state_next  = S_TEST;
            end
            S_TEST:
            begin
                cmd.mul_sel = mbe_pkg::MUL_RI;
                cmd.ii_en   = 1'b1;
                state_next  = status.stop ? S_DONE : S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.upd_en = 1'b1;
                state_next = S_SQ_RE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted transaction did not start work");

    a_update_after_test: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_en |-> $past(state_reg == S_TEST) && !$past(status.stop))
        else $error("update without a passing test");

endmodule

`default_nettype wire

### hw/rtl/mbe_dp.sv
// Escape-time datapath: one shared 32x32 multiplier, c mapping, z update,
// escape test and iteration counter. Depends on mbe_pkg.
`default_nettype none

module mbe_dp
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mbe_pkg::cfg_t                 cfg,
    input  wire mbe_pkg::dp_cmd_t              cmd,
    output mbe_pkg::dp_status_t                status,
    input  wire logic [mbe_pkg::PIX_W-1:0]     pixel_x,
    input  wire logic [mbe_pkg::PIX_W-1:0]     pixel_y,
    output logic [mbe_pkg::PIX_W-1:0]          out_x,
    output logic [mbe_pkg::PIX_W-1:0]          out_y,
    output logic [mbe_pkg::ITER_W-1:0]         iterations,
    output logic                               inside_res
);

    localparam int unsigned CW = mbe_pkg::COORD_W;
    localparam int unsigned PW = mbe_pkg::PROD_W;

    logic [mbe_pkg::PIX_W-1:0]  px_reg;
    logic [mbe_pkg::PIX_W-1:0]  py_reg;
    logic signed [CW-1:0]       cr_reg;
    logic signed [CW-1:0]       ci_reg;
    logic signed [CW-1:0]       zr_reg;
    logic signed [CW-1:0]       zi_reg;
    logic signed [PW-1:0]       prod_reg;
    logic signed [PW-1:0]       rr_reg;
    logic signed [PW-1:0]       ii_reg;
    logic [mbe_pkg::ITER_W-1:0] n_reg;

    logic signed [CW-1:0]       mul_a;
    logic signed [CW-1:0]       mul_b;
    logic signed [PW-1:0]       prod_next;
    logic [PW-1:0]              mag;
    logic signed [PW-1:0]       rr_ii_diff;
    logic signed [CW-1:0]       zr_next;
    logic signed [CW-1:0]       zi_next;

    always_comb
    begin
        unique case (cmd.mul_sel)
            mbe_pkg::MUL_MAP_RE:
            begin
                mul_a = $signed({{(CW - mbe_pkg::PIX_W){1'b0}}, px_reg});
                mul_b = cfg.re_step;
            end
            mbe_pkg::MUL_MAP_IM:
            begin
                mul_a = $signed({{(CW - mbe_pkg::PIX_W){1'b0}}, py_reg});
                mul_b = cfg.im_step;
            end
            mbe_pkg::MUL_ZR2:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            mbe_pkg::MUL_ZI2:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            mbe_pkg::MUL_RI:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // In the test cycle the product register holds zi^2
    assign mag         = $unsigned(rr_reg) + $unsigned(prod_reg);
    assign status.stop = (mag > mbe_pkg::ESCAPE_LIMIT) || (n_reg >= cfg.max_iter);

    // In the update cycle the product register holds zr*zi
    assign rr_ii_diff = rr_reg - ii_reg;
    assign zr_next    = mbe_pkg::sat32((rr_ii_diff >>> mbe_pkg::FRAC_BITS)
                                       + mbe_pkg::sext64(cr_reg));
    assign zi_next    = mbe_pkg::sat32((prod_reg >>> (mbe_pkg::FRAC_BITS - 1))
                                       + mbe_pkg::sext64(ci_reg));

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.load)
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
            zr_reg <= '0;
            zi_reg <= '0;
        end
        else if (cmd.upd_en)
        begin
            zr_reg <= zr_next;
            zi_reg <= zi_next;
        end
        if (cmd.cr_en)
        begin
            cr_reg <= mbe_pkg::sat32(prod_reg + mbe_pkg::sext64(cfg.re_origin));
        end
        if (cmd.ci_en)
        begin
            ci_reg <= mbe_pkg::sat32(prod_reg + mbe_pkg::sext64(cfg.im_origin));
        end
        if (cmd.rr_en)
        begin
            rr_reg <= prod_reg;
        end
        if (cmd.ii_en)
        begin
            ii_reg <= prod_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
        end
        else if (cmd.load)
        begin
            n_reg <= '0;
        end
        else if (cmd.upd_en)
        begin
            n_reg <= n_reg + 1'b1;
        end
    end

    assign out_x      = px_reg;
    assign out_y      = py_reg;
    assign iterations = n_reg;
    assign inside_res = (n_reg == cfg.max_iter);

    a_upd_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_en |-> (n_reg < cfg.max_iter))
        else $error("iteration advanced at or past the limit");

    a_upd_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_en |=> (n_reg == $past(n_reg) + 1'b1))
        else $error("iteration count did not advance");

endmodule

`default_nettype wire

### hw/rtl/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time evaluator.
// Depends on mbe_pkg, mbe_cfg, mbe_ctrl and mbe_dp.
//
// Usage
//   Command channel: drive pixel_x/pixel_y and raise start; the transaction
//   is taken at a clock edge where start is high and busy is low. busy stays
//   high until the result has been shown.
//   Result channel: done is high for exactly one cycle with out_x, out_y,
//   iterations and inside_res valid in that cycle. The receiver must take
//   the transaction then; there is no way to hold it off.
//   Configuration channel: cfg_valid/cfg_ready with cfg_index (0 re_origin,
//   1 re_step, 2 im_origin, 3 im_step, 4 max_iter) and cfg_data. Write only
//   while busy is low; cfg_ready is always high, unused indexes are dropped.
// Timing
//   One shared 32x32 multiplier sets the pace: mapping c runs through
//   MAP_RE, MAP_IM and MAP_FN, and each iteration of z = z*z + c steps
//   through zr^2, zi^2, escape test with zr*zi, and update. The next
//   command is taken the cycle after done.
// Reset
//   rst_n is asynchronous, active low; it drops any transaction in flight
//   and loads the default window (-2, -2) at 1/256 per pixel and limit 100.
`default_nettype none

module mandelbrot_escape_time
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [mbe_pkg::PIX_W-1:0]      pixel_x,
    input  wire logic [mbe_pkg::PIX_W-1:0]      pixel_y,
    output logic                                done,
    output logic [mbe_pkg::PIX_W-1:0]           out_x,
    output logic [mbe_pkg::PIX_W-1:0]           out_y,
    output logic [mbe_pkg::ITER_W-1:0]          iterations,
    output logic                                inside_res,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data
);

    mbe_pkg::cfg_t      cfg;
    mbe_pkg::dp_cmd_t   cmd;
    mbe_pkg::dp_status_t status;

    // Window and limit registers
    mbe_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer: issues one datapath command per cycle
    mbe_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    // Arithmetic: c mapping, z iteration, escape test, counter
    mbe_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .status     (status),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .out_x      (out_x),
        .out_y      (out_y),
        .iterations (iterations),
        .inside_res (inside_res)
    );

endmodule

`default_nettype wire

### test/mandelbrot_escape_time_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for mandelbrot_escape_time: pixel and register transactions
// come from a job queue, and each result is checked against a Q4.28 escape-time predictor.
// Depends on mbe_pkg and the mandelbrot_escape_time RTL.

module mandelbrot_escape_time_test;

    localparam int unsigned PIX_W      = mbe_pkg::PIX_W;
    localparam int unsigned ITER_W     = mbe_pkg::ITER_W;
    localparam int unsigned CFG_IDX_W  = mbe_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W = mbe_pkg::CFG_DATA_W;

    localparam int RESET_CYCLES   = 11;
    localparam int IDLE_PCT       = 20;
    localparam int MAX_GAP        = 60;
    localparam int PHASES         = 12;
    localparam int PHASE_PIXELS   = 150;
    localparam int TAIL_CYCLES    = 40;
    localparam int REPORT_CAP     = 200;
    // The slowest legal transaction is an inside point at limit 65535.
    localparam int WATCHDOG_LIMIT = 1 << 20;

    localparam int Q_FRAC = 28;
    localparam int Q_ONE  = 1 << Q_FRAC;
    localparam int Q_MAX  = 32'sh7FFF_FFFF;
    localparam int Q_MIN  = 32'sh8000_0000;
    // Escape bound |z|^2 > 4.0, in Q8.56
    localparam logic [63:0] RADIUS_SQ = 64'd4 << (2 * Q_FRAC);

    typedef enum logic [1:0] {
        JOB_PIXEL,
        JOB_REG_WRITE,
        JOB_DRAIN
    } job_kind_t;

    typedef struct {
        job_kind_t              kind;
        logic [PIX_W-1:0]       x;
        logic [PIX_W-1:0]       y;
        int unsigned            gap;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
    } job_t;

    typedef struct packed {
        logic [PIX_W-1:0]  x;
        logic [PIX_W-1:0]  y;
        logic [ITER_W-1:0] iters;
        logic              in_set;
    } escape_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   start = 1'b0;
    logic                   busy;
    logic [PIX_W-1:0]       pixel_x = '0;
    logic [PIX_W-1:0]       pixel_y = '0;
    logic                   done;
    logic [PIX_W-1:0]       out_x;
    logic [PIX_W-1:0]       out_y;
    logic [ITER_W-1:0]      iterations;
    logic                   inside_res;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    job_t          job_q[$];
    escape_t       awaited_escapes[$];
    mbe_pkg::cfg_t window;          // predictor copy of the register file
    logic          cmd_taken = 1'b0;
    logic          cfg_taken = 1'b0;
    int unsigned   fail_count = 0;
    int unsigned   stall_cycles = 0;

    mandelbrot_escape_time dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .done       (done),
        .out_x      (out_x),
        .out_y      (out_y),
        .iterations (iterations),
        .inside_res (inside_res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp to the signed Q4.28 range.
    function automatic int clamp_q428(input longint v);
        if (v > Q_MAX)
        begin
            return Q_MAX;
        end
        if (v < Q_MIN)
        begin
            return Q_MIN;
        end
        return int'(v);
    endfunction

    // Map the pixel to c, then iterate z = z*z + c from zero while |z|^2 <= 4 and
    // the count is under the limit. Squares stay exact in 64 bits; rescaling is an
    // arithmetic shift, so it rounds toward minus infinity.
    function automatic escape_t escape_time(input mbe_pkg::cfg_t regs,
                                            input logic [PIX_W-1:0] px,
                                            input logic [PIX_W-1:0] py);
        escape_t     res;
        int          cr;
        int          ci;
        int          zr;
        int          zi;
        int          zr_next;
        longint      rr;
        longint      ii;
        logic [63:0] mag;
        int unsigned n;
        int unsigned limit;
        cr = clamp_q428(longint'(int'(regs.re_origin))
                        + longint'(px) * longint'(int'(regs.re_step)));
        ci = clamp_q428(longint'(int'(regs.im_origin))
                        + longint'(py) * longint'(int'(regs.im_step)));
        zr = 0;
        zi = 0;
        rr = 0;
        ii = 0;
        mag = '0;
        n = 0;
        limit = regs.max_iter;
        while (n < limit && mag <= RADIUS_SQ)
        begin
            zr_next = clamp_q428(((rr - ii) >>> Q_FRAC) + longint'(cr));
            zi = clamp_q428(((longint'(zr) * longint'(zi)) >>> (Q_FRAC - 1)) + longint'(ci));
            zr = zr_next;
            n++;
            rr = longint'(zr) * longint'(zr);
            ii = longint'(zi) * longint'(zi);
            mag = rr + ii;     // up to 2^63, so compare unsigned
        end
        res.x = px;
        res.y = py;
        res.iters = ITER_W'(n);
        res.in_set = (n == limit);
        return res;
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_CAP)
        begin
            $error("%s", msg);
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            report_failure($sformatf("%s: expected %0d, got %0d", field, want, got));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: advance through the job queue at the falling edge.
    // Hold start (or cfg_valid) until the monitor sees the transaction taken,
    // then drop it or present the next job in the same step, with one
    // nonblocking assignment per signal.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        logic                  nxt_start;
        logic                  nxt_cfg_valid;
        logic [PIX_W-1:0]      nxt_x;
        logic [PIX_W-1:0]      nxt_y;
        logic [CFG_IDX_W-1:0]  nxt_idx;
        logic [CFG_DATA_W-1:0] nxt_data;
        logic                  quiet;
        nxt_start = start;
        nxt_cfg_valid = cfg_valid;
        nxt_x = pixel_x;
        nxt_y = pixel_y;
        nxt_idx = cfg_index;
        nxt_data = cfg_data;
        if (rst_n)
        begin
            if (cmd_taken)
            begin
                nxt_start = 1'b0;
            end
            if (cfg_taken)
            begin
                nxt_cfg_valid = 1'b0;
            end
            // Idle means nothing presented, nothing in flight, no result owed.
            quiet = !nxt_start && !nxt_cfg_valid && !busy && awaited_escapes.size() == 0;
            if (!nxt_start && !nxt_cfg_valid && job_q.size() != 0)
            begin
                case (job_q[0].kind)
                    JOB_PIXEL:
                    begin
                        // Count the gap down only while the block could take a command.
                        if (job_q[0].gap != 0)
                        begin
                            if (!busy)
                            begin
                                job_q[0].gap = job_q[0].gap - 1;
                            end
                        end
                        else
                        begin
                            nxt_x = job_q[0].x;
                            nxt_y = job_q[0].y;
                            nxt_start = 1'b1;
                            job_q.delete(0);
                        end
                    end
                    JOB_REG_WRITE:
                    begin
                        // Registers change only with the block idle.
                        if (quiet)
                        begin
                            nxt_idx = job_q[0].reg_idx;
                            nxt_data = job_q[0].reg_val;
                            nxt_cfg_valid = 1'b1;
                            job_q.delete(0);
                        end
                    end
                    default:
                    begin
                        if (quiet)
                        begin
                            job_q.delete(0);
                        end
                    end
                endcase
            end
        end
        start <= nxt_start;
        cfg_valid <= nxt_cfg_valid;
        pixel_x <= nxt_x;
        pixel_y <= nxt_y;
        cfg_index <= nxt_idx;
        cfg_data <= nxt_data;
    end

    // ------------------------------------------------------------------
    // Monitor: sample all three channels at the rising edge. Check a result
    // against the oldest expectation first, then apply any register write and
    // predict any pixel transaction taken at this edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        escape_t want;
        if (!rst_n)
        begin
            window = '{mbe_pkg::RST_RE_ORIGIN, mbe_pkg::RST_RE_STEP, mbe_pkg::RST_IM_ORIGIN,
                       mbe_pkg::RST_IM_STEP, mbe_pkg::RST_MAX_ITER};
        end
        else
        begin
            cmd_taken <= start && !busy;
            cfg_taken <= cfg_valid && cfg_ready;
            if (done)
            begin
                if (awaited_escapes.size() == 0)
                begin
                    report_failure($sformatf("result for pixel (%0d, %0d) with no transaction outstanding",
                                             out_x, out_y));
                end
                else
                begin
                    want = awaited_escapes.pop_front();
                    check_field("out_x", 32'(want.x), 32'(out_x));
                    check_field("out_y", 32'(want.y), 32'(out_y));
                    check_field("iterations", 32'(want.iters), 32'(iterations));
                    check_field("inside_res", 32'(want.in_set), 32'(inside_res));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mbe_pkg::REG_RE_ORIGIN: window.re_origin = cfg_data;
                    mbe_pkg::REG_RE_STEP:   window.re_step = cfg_data;
                    mbe_pkg::REG_IM_ORIGIN: window.im_origin = cfg_data;
                    mbe_pkg::REG_IM_STEP:   window.im_step = cfg_data;
                    mbe_pkg::REG_MAX_ITER:  window.max_iter = cfg_data[ITER_W-1:0];
                    default: ;     // unused indexes leave the registers alone
                endcase
            end
            if (start && !busy)
            begin
                awaited_escapes.push_back(escape_time(window, pixel_x, pixel_y));
            end
            // Watchdog: any transaction on any channel counts as progress.
            if ((start && !busy) || (cfg_valid && cfg_ready) || done)
            begin
                stall_cycles = 0;
            end
            else if (stall_cycles == WATCHDOG_LIMIT)
            begin
                $display("[mandelbrot_escape_time] ERROR");
                $finish;
            end
            else
            begin
                stall_cycles++;
            end
        end
    end

    task automatic push_pixel(input int x, input int y, input int idle_pct);
        job_t job;
        job.kind = JOB_PIXEL;
        job.x = PIX_W'(x);
        job.y = PIX_W'(y);
        job.gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, MAX_GAP) : 0;
        job.reg_idx = '0;
        job.reg_val = '0;
        job_q.push_back(job);
    endtask

    task automatic push_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        job_t job;
        job.kind = JOB_REG_WRITE;
        job.x = '0;
        job.y = '0;
        job.gap = 0;
        job.reg_idx = idx;
        job.reg_val = val;
        job_q.push_back(job);
    endtask

    task automatic push_drain();
        job_t job;
        job.kind = JOB_DRAIN;
        job.x = '0;
        job.y = '0;
        job.gap = 0;
        job.reg_idx = '0;
        job.reg_val = '0;
        job_q.push_back(job);
    endtask

    // Limit word with random junk in the bits above the limit field.
    function automatic logic [CFG_DATA_W-1:0] limit_word(input int unsigned lim);
        return {(CFG_DATA_W - ITER_W)'($urandom()), ITER_W'(lim)};
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: fill the job queue, release reset, wait for the queue and
    // all outstanding results to drain, then report.
    // ------------------------------------------------------------------
    initial
    begin
        int          mode;
        int          idle_pct;
        int unsigned lim;
        int          re_org;
        int          im_org;
        int          re_stp;
        int          im_stp;

        // Reset window: corner (-2,-2), the origin, the point -2 whose orbit sits
        // exactly on |z|^2 = 4, and the far corners.
        push_pixel(0, 0, IDLE_PCT);
        push_pixel(512, 512, IDLE_PCT);
        push_pixel(0, 512, IDLE_PCT);
        push_pixel(1023, 1023, IDLE_PCT);
        push_pixel(1023, 0, IDLE_PCT);
        push_pixel(0, 1023, IDLE_PCT);

        // Saturate c on both axes: full-scale positive and negative origin and step.
        push_drain();
        push_reg(mbe_pkg::REG_RE_ORIGIN, 32'h7FFF_FFFF);
        push_reg(mbe_pkg::REG_RE_STEP, 32'h7FFF_FFFF);
        push_reg(mbe_pkg::REG_IM_ORIGIN, 32'h8000_0000);
        push_reg(mbe_pkg::REG_IM_STEP, 32'h8000_0000);
        push_reg(mbe_pkg::REG_MAX_ITER, limit_word(1));
        push_pixel(1023, 1023, IDLE_PCT);
        push_pixel(1, 0, IDLE_PCT);
        push_pixel(0, 1, IDLE_PCT);

        // Zero limit at c = 0, then junk writes to the unused indexes; any alias onto
        // a live register would move c away from zero or change the limit.
        push_drain();
        push_reg(mbe_pkg::REG_RE_ORIGIN, '0);
        push_reg(mbe_pkg::REG_RE_STEP, '0);
        push_reg(mbe_pkg::REG_IM_ORIGIN, '0);
        push_reg(mbe_pkg::REG_IM_STEP, '0);
        push_reg(mbe_pkg::REG_MAX_ITER, limit_word(0));
        for (int r = mbe_pkg::REG_MAX_ITER + 1; r < 2 ** CFG_IDX_W; r++)
        begin
            push_reg(CFG_IDX_W'(r), $urandom());
        end
        push_pixel(1023, 0, IDLE_PCT);
        push_pixel(0, 1023, IDLE_PCT);

        // Largest limit: one inside point runs the counter all the way up.
        push_drain();
        push_reg(mbe_pkg::REG_RE_ORIGIN, mbe_pkg::RST_RE_ORIGIN);
        push_reg(mbe_pkg::REG_RE_STEP, mbe_pkg::RST_RE_STEP);
        push_reg(mbe_pkg::REG_IM_ORIGIN, mbe_pkg::RST_IM_ORIGIN);
        push_reg(mbe_pkg::REG_IM_STEP, mbe_pkg::RST_IM_STEP);
        push_reg(mbe_pkg::REG_MAX_ITER, limit_word(2 ** ITER_W - 1));
        push_pixel(512, 512, IDLE_PCT);
        push_pixel(0, 0, IDLE_PCT);
        push_pixel(1023, 1023, IDLE_PCT);

        // Negative steps walk the window backwards.
        push_drain();
        push_reg(mbe_pkg::REG_RE_ORIGIN, Q_ONE);
        push_reg(mbe_pkg::REG_RE_STEP, -(Q_ONE >>> 8));
        push_reg(mbe_pkg::REG_IM_ORIGIN, Q_ONE + Q_ONE / 2);
        push_reg(mbe_pkg::REG_IM_STEP, -(Q_ONE >>> 9));
        push_reg(mbe_pkg::REG_MAX_ITER, limit_word(48));
        push_pixel(1023, 1023, IDLE_PCT);
        push_pixel(700, 300, IDLE_PCT);
        push_pixel(0, 0, IDLE_PCT);
        push_pixel(511, 767, IDLE_PCT);

        // Random phases, each with a fresh register set written while idle.
        for (int p = 0; p < PHASES; p++)
        begin
            mode = $urandom_range(0, 3);
            // One long stretch with no random idle gaps before its pixels.
            idle_pct = (p == PHASES / 3) ? 0 : IDLE_PCT;
            re_org = int'($urandom_range(0, 7 * Q_ONE / 2)) - 5 * Q_ONE / 2;
            im_org = int'($urandom_range(0, 3 * Q_ONE)) - 2 * Q_ONE;
            re_stp = $urandom_range(1 << 14, 1 << 21);
            im_stp = $urandom_range(1 << 14, 1 << 21);
            if ($urandom_range(0, 3) == 0)
            begin
                re_stp = -re_stp;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                im_stp = -im_stp;
            end
            lim = $urandom_range(1, 48);
            if (mode == 2)
            begin
                // Raw register words: mostly far-out c, often saturated.
                re_org = $urandom();
                im_org = $urandom();
                re_stp = $urandom();
                im_stp = $urandom();
            end
            else if (mode == 3)
            begin
                lim = $urandom_range(64, 160);
            end
            push_drain();
            push_reg(mbe_pkg::REG_RE_ORIGIN, re_org);
            push_reg(mbe_pkg::REG_RE_STEP, re_stp);
            push_reg(mbe_pkg::REG_IM_ORIGIN, im_org);
            push_reg(mbe_pkg::REG_IM_STEP, im_stp);
            push_reg(mbe_pkg::REG_MAX_ITER, limit_word(lim));
            for (int i = 0; i < PHASE_PIXELS; i++)
            begin
                // Now and then hold the sender until every result is in.
                if ($urandom_range(0, 63) == 0)
                begin
                    push_drain();
                end
                push_pixel($urandom_range(0, 1023), $urandom_range(0, 1023), idle_pct);
            end
        end

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Poll at the rising edge, where the driven inputs are settled.
        while (job_q.size() != 0 || start || cfg_valid || awaited_escapes.size() != 0)
        begin
            @(posedge clk);
        end
        // Leave room for any stray result to show up.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("[mandelbrot_escape_time] OK");
        end
        else
        begin
            $display("[mandelbrot_escape_time] ERROR");
        end
        $finish;
    end

endmodule
